FILE: rtl/ideacfb_pkg.sv
// ----------------------------------------------------------------------------
// ideacfb_pkg
// Shared widths, register indexes and defaults for the IDEA CFB byte cipher.
// ----------------------------------------------------------------------------
package ideacfb_pkg;

  localparam int DefaultRounds = 8;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH     = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW      = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_VECTOR  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_DECRYPT_MODE = 4'd3;

  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

endpackage

FILE: rtl/ideacfb_if.sv
// ----------------------------------------------------------------------------
// ideacfb channel interfaces
// Valid/ready channels for the input items and the result bytes.
// ----------------------------------------------------------------------------
interface ideacfb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface ideacfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

FILE: rtl/ideacfb_mulmod.sv
// ----------------------------------------------------------------------------
// ideacfb_mulmod
// Multiply modulo 65537 (zero stands for 65536). Product registered, result
// reduced from the register in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module ideacfb_mulmod (
  input  logic        clk,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] y
);

  logic [16:0] ax;
  logic [16:0] bx;
  logic [33:0] full;
  logic [32:0] prod;
  logic [17:0] diff;
  logic [17:0] r;

  assign ax   = (a == 16'd0) ? 17'h10000 : {1'b0, a};
  assign bx   = (b == 16'd0) ? 17'h10000 : {1'b0, b};
  assign full = ax * bx;

  always_ff @(posedge clk) begin
    prod <= full[32:0];
  end

  // hi*2^16 + lo == lo - hi (mod 65537)
  assign diff = {2'b00, prod[15:0]} - {1'b0, prod[32:16]};
  assign r    = diff[17] ? (diff + 18'd65537) : diff;
  assign y    = r[15:0];

endmodule

FILE: rtl/idea_cfb_byte_stream_cipher.sv
// ----------------------------------------------------------------------------
// idea_cfb_byte_stream_cipher
// Byte-serial IDEA in 64-bit CFB mode with an iterative shared mod-65537
// multiplier and on-the-fly subkey generation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_item   in   valid/ready    cmd, data_in
//  out_item  out  valid/ready    data_out
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// A data byte with keystream left is accepted, then delivered from S_OUT.
// A byte that needs a refill first runs the block cipher: it performs one
// operation at a time through one shared multiplier, a multiply waiting on
// the registered product, and uses one subkey per operation.
// A restart is accepted in S_IDLE and gives no result.
// rst is synchronous; it clears control state and the feedback register.
// A stalled output holds the finished byte; the next item is still accepted
// while it waits, and the block pauses only when a second byte is ready.
// ----------------------------------------------------------------------------
module idea_cfb_byte_stream_cipher #(
  parameter int ROUNDS = ideacfb_pkg::DefaultRounds
) (
  input  logic                             clk,
  input  logic                             rst,
  ideacfb_in_if.sink                       in_item,
  ideacfb_out_if.source                    out_item,
  input  logic                             cfg_we,
  input  logic [ideacfb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ideacfb_pkg::CfgDataW-1:0] cfg_data
);

  localparam int RW = $clog2(ROUNDS + 1);
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CIPHER = 3'b010,
    S_OUT    = 3'b100
  } state_t;

  state_t state;

  // configuration
  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [63:0]  init_vector;
  logic         decrypt_mode;

  // key snapshot taken at restart, and the rotating subkey source
  logic [127:0] key_snap;
  logic [127:0] key_rot;
  logic [2:0]   key_pos;
  logic [15:0]  subkey;

  logic [63:0]  fb;
  logic [3:0]   bytes_left;
  logic [7:0]   din;

  // cipher datapath
  logic [15:0]  x1, x2, x3, x4, t;
  logic [RW-1:0] rnd;
  logic [2:0]   op;
  logic         phase;
  logic         last;

  logic [15:0]  mul_a;
  logic [15:0]  mul_y;
  logic [15:0]  sum;

  logic         out_valid;
  logic [7:0]   out_data;
  logic         slot_free;
  logic [2:0]   byte_sel;
  logic [7:0]   ks;
  logic [7:0]   dout;
  logic [63:0]  fb_next;
  logic         in_fire;
  logic         cipher_done;

  assign subkey    = key_rot[127:112];
  assign last      = (rnd == LAST_ROUND);
  assign slot_free = !out_valid || out_item.ready;
  assign in_fire   = in_item.valid && in_item.ready;

  assign in_item.ready     = (state == S_IDLE);
  assign out_item.valid    = out_valid;
  assign out_item.data_out = out_data;

  // operand mux for the shared multiplier
  always_comb begin
    case (op)
      3'd0:    mul_a = x1;
      3'd3:    mul_a = x4;
      3'd4:    mul_a = x3 ^ x1;
      3'd5:    mul_a = (x2 ^ x4) + t;
      default: mul_a = x1;
    endcase
  end

  ideacfb_mulmod u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (subkey),
    .y   (mul_y)
  );

  assign sum = t + mul_y;

  // keystream byte: most significant unused byte first
  assign byte_sel = 3'(bytes_left - 4'd1);
  assign ks       = fb[{byte_sel, 3'b000} +: 8];
  assign dout     = ks ^ din;

  always_comb begin
    fb_next = fb;
    fb_next[{byte_sel, 3'b000} +: 8] = decrypt_mode ? din : dout;
  end

  assign cipher_done = (state == S_CIPHER) && (op == 3'd3) && phase && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      init_vector  <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ideacfb_pkg::REG_KEY_HIGH:     key_high     <= cfg_data;
        ideacfb_pkg::REG_KEY_LOW:      key_low      <= cfg_data;
        ideacfb_pkg::REG_INIT_VECTOR:  init_vector  <= cfg_data;
        ideacfb_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fb         <= '0;
      bytes_left <= '0;
      out_valid  <= 1'b0;
      op         <= '0;
      phase      <= 1'b0;
      rnd        <= '0;
      key_pos    <= '0;
    end else begin
      // S_OUT sets out_valid itself when the slot frees up
      if (out_item.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_item.cmd == ideacfb_pkg::CMD_RESTART) begin
              key_snap   <= {key_high, key_low};
              fb         <= init_vector;
              bytes_left <= '0;
            end else begin
              din <= in_item.data_in;
              if (bytes_left == 4'd0) begin
                // refill: start the block cipher on the feedback register
                x1      <= fb[63:48];
                x2      <= fb[47:32];
                x3      <= fb[31:16];
                x4      <= fb[15:0];
                key_rot <= key_snap;
                key_pos <= '0;
                op      <= '0;
                phase   <= 1'b0;
                rnd     <= '0;
                state   <= S_CIPHER;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end

        S_CIPHER: begin
          if (!phase && (op == 3'd0 || op >= 3'd3)) begin
            // multiply issued this cycle; result lands next cycle
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            // consume one subkey: rotate by 16, or by 25 net at group end
            key_pos <= key_pos + 3'd1;
            if (key_pos == 3'd7) begin
              key_rot <= {key_rot[86:0], key_rot[127:87]};
            end else begin
              key_rot <= {key_rot[111:0], key_rot[127:112]};
            end
            op <= (op == 3'd5) ? 3'd0 : op + 3'd1;
            case (op)
              3'd0: x1 <= mul_y;
              3'd1: begin
                if (last) x3 <= x3 + subkey;
                else      x2 <= x2 + subkey;
              end
              3'd2: begin
                if (last) x2 <= x2 + subkey;
                else      x3 <= x3 + subkey;
              end
              3'd3: begin
                x4 <= mul_y;
                if (last) begin
                  // output transform swaps the middle words
                  fb         <= {x1, x3, x2, mul_y};
                  bytes_left <= 4'd8;
                  state      <= S_OUT;
                end
              end
              3'd4: t <= mul_y;
              3'd5: begin
                // mul_y is the second MA output; sum is the first
                x1  <= x1 ^ mul_y;
                x2  <= x3 ^ mul_y;
                x3  <= x2 ^ sum;
                x4  <= x4 ^ sum;
                rnd <= rnd + RW'(1);
              end
              default: ;
            endcase
          end
        end

        S_OUT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_data   <= dout;
            fb         <= fb_next;
            bytes_left <= bytes_left - 4'd1;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // keystream count never exceeds one block
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 4'd8)
    else $error("keystream count out of range");

  // finishing the block cipher leaves a full keystream block
  a_refill: assert property (@(posedge clk) disable iff (rst)
    cipher_done |=> (bytes_left == 4'd8) && (state == S_OUT))
    else $error("refill did not reload keystream");

  // a data byte with keystream left goes straight to delivery
  a_no_refill: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.cmd == ideacfb_pkg::CMD_DATA && bytes_left != 4'd0)
      |=> (state == S_OUT))
    else $error("unneeded refill");

  // the multiplier is never addressed beyond the last op of a round
  a_op_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CIPHER) |-> (op <= 3'd5) && (rnd <= LAST_ROUND))
    else $error("sequencer out of range");

endmodule

FILE: test/idea_cfb_byte_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// idea_cfb_byte_stream_cipher_tb
// Drives restarts and data bytes into the IDEA CFB byte cipher and checks
// every output byte against an in-bench cipher predictor.
// ----------------------------------------------------------------------------
class cfb_byte_scoreboard;
  byte unsigned pending[$];
  int           mismatches;
  int           checked;

  function void note_byte(byte unsigned b);
    pending.push_back(b);
  endfunction

  function void check_byte(byte unsigned got);
    byte unsigned want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output byte %02h", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) $display("byte mismatch: expected %02h actual %02h", want, got);
    end
  endfunction
endclass

module idea_cfb_byte_stream_cipher_tb;

  localparam int NumRandom  = 950;
  localparam int WatchLimit = 20000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [ideacfb_pkg::CfgIdxW-1:0]     cfg_index = '0;
  logic [ideacfb_pkg::CfgDataW-1:0]    cfg_data = '0;

  ideacfb_in_if  in_item();
  ideacfb_out_if out_item();

  idea_cfb_byte_stream_cipher u_dut (
    .clk(clk), .rst(rst), .in_item(in_item), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: registers mirrored from writes, cipher state from items.
  logic [63:0] key_hi_q, key_lo_q, iv_q;
  logic        decrypt_q;
  logic [63:0] feedback;
  int          ks_left;
  logic [15:0] subkey[52];

  cfb_byte_scoreboard sb = new();
  bit quiet_sink;   // no stalls on the output side
  bit quiet_src;    // no gaps on the input side
  int idle_cycles;
  int restarts, data_bytes;

  function automatic logic [15:0] mul_mod(logic [15:0] a, logic [15:0] b);
    logic [33:0] x, y, p;
    x = (a == 16'h0) ? 34'h10000 : {18'h0, a};
    y = (b == 16'h0) ? 34'h10000 : {18'h0, b};
    p = (x * y) % 34'd65537;
    return p[15:0];
  endfunction

  function automatic void expand_subkeys();
    logic [127:0] k;
    k = {key_hi_q, key_lo_q};
    for (int n = 0; n < 52; n++) begin
      subkey[n] = k[127 - 16 * (n % 8) -: 16];
      if (n % 8 == 7) k = {k[102:0], k[127:103]};
    end
  endfunction

  function automatic logic [63:0] idea_block(logic [63:0] blk);
    logic [15:0] x1, x2, x3, x4, s2, s3;
    int k;
    {x1, x2, x3, x4} = blk;
    k = 0;
    for (int r = 0; r < ideacfb_pkg::DefaultRounds; r++) begin
      x1 = mul_mod(x1, subkey[k]);
      x2 = x2 + subkey[k+1];
      x3 = x3 + subkey[k+2];
      x4 = mul_mod(x4, subkey[k+3]);
      s3 = x3;
      x3 = mul_mod(x3 ^ x1, subkey[k+4]);
      s2 = x2;
      x2 = mul_mod((x2 ^ x4) + x3, subkey[k+5]);
      x3 = x3 + x2;
      x1 ^= x2;
      x4 ^= x3;
      x2 ^= s3;
      x3 ^= s2;
      k += 6;
    end
    x1 = mul_mod(x1, subkey[k]);
    x3 = x3 + subkey[k+1];
    x2 = x2 + subkey[k+2];
    x4 = mul_mod(x4, subkey[k+3]);
    return {x1, x3, x2, x4};
  endfunction

  // Advance the cipher model by one accepted transaction.
  function automatic void predict_item(logic c, logic [7:0] din);
    int sh;
    logic [7:0] dout;
    if (c == ideacfb_pkg::CMD_RESTART) begin
      expand_subkeys();
      feedback = iv_q;
      ks_left  = 0;
      restarts++;
      return;
    end
    if (ks_left == 0) begin
      feedback = idea_block(feedback);
      ks_left  = 8;
    end
    sh   = 56 - 8 * (8 - ks_left);
    dout = feedback[sh +: 8] ^ din;
    feedback[sh +: 8] = decrypt_q ? din : dout;
    ks_left--;
    data_bytes++;
    sb.note_byte(dout);
  endfunction

  task automatic write_reg(logic [ideacfb_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      ideacfb_pkg::REG_KEY_HIGH:     key_hi_q  = val;
      ideacfb_pkg::REG_KEY_LOW:      key_lo_q  = val;
      ideacfb_pkg::REG_INIT_VECTOR:  iv_q      = val;
      ideacfb_pkg::REG_DECRYPT_MODE: decrypt_q = val[0];
      default: ;
    endcase
  endtask

  // One transaction; valid stays high across back-to-back items.
  task automatic send_item(logic c, logic [7:0] din);
    while (!quiet_src && $urandom_range(99) < 20) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid   <= 1'b1;
    in_item.cmd     <= c;
    in_item.data_in <= din;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    predict_item(c, din);
  endtask

  task automatic end_burst();
    in_item.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every byte is out, plus the refill latency, before a write.
  task automatic drain();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_keys();
    write_reg(ideacfb_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(ideacfb_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_reg(ideacfb_pkg::REG_INIT_VECTOR, {$urandom, $urandom});
  endtask

  // Output sink: random stalls, checking on every transaction.
  always @(posedge clk) begin
    if (rst) begin
      out_item.ready <= 1'b0;
    end else begin
      if (out_item.valid && out_item.ready) sb.check_byte(out_item.data_out);
      out_item.ready <= quiet_sink || ($urandom_range(99) >= 20);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)
        || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchLimit);
        $display("** idea_cfb_byte_stream_cipher: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] b;
    in_item.valid   = 1'b0;
    in_item.cmd     = ideacfb_pkg::CMD_DATA;
    in_item.data_in = 8'h00;
    key_hi_q = '0; key_lo_q = '0; iv_q = '0; decrypt_q = 1'b0;
    feedback = '0; ks_left = 0;
    restarts = 0; data_bytes = 0;
    quiet_sink = 1'b0; quiet_src = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-zero key, then all-ones extremes, both modes.
    write_reg(ideacfb_pkg::REG_KEY_HIGH, 64'h0);
    write_reg(ideacfb_pkg::REG_KEY_LOW, 64'h0);
    write_reg(ideacfb_pkg::REG_INIT_VECTOR, 64'h0);
    write_reg(ideacfb_pkg::REG_DECRYPT_MODE, 64'h0);
    write_reg(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);   // unmapped index, ignored
    send_item(ideacfb_pkg::CMD_RESTART, 8'h00);
    send_item(ideacfb_pkg::CMD_DATA, 8'h00);
    send_item(ideacfb_pkg::CMD_DATA, 8'hFF);
    drain();
    write_reg(ideacfb_pkg::REG_KEY_HIGH, '1);
    write_reg(ideacfb_pkg::REG_KEY_LOW, '1);
    write_reg(ideacfb_pkg::REG_INIT_VECTOR, '1);
    write_reg(ideacfb_pkg::REG_DECRYPT_MODE, 64'h1);
    send_item(ideacfb_pkg::CMD_RESTART, 8'hA5);
    for (int i = 0; i < 9; i++) send_item(ideacfb_pkg::CMD_DATA, (i % 2) ? 8'hFF : 8'h00);
    drain();
    // Key change without restart: old subkeys stay until the next restart.
    write_reg(ideacfb_pkg::REG_KEY_HIGH, 64'h0001_0002_0003_0004);
    write_reg(ideacfb_pkg::REG_KEY_LOW, 64'h0005_0006_0007_0008);
    write_reg(ideacfb_pkg::REG_DECRYPT_MODE, 64'h0);   // mode change mid-stream
    for (int i = 0; i < 4; i++) send_item(ideacfb_pkg::CMD_DATA, 8'h5A);
    send_item(ideacfb_pkg::CMD_RESTART, 8'h00);
    for (int i = 0; i < 4; i++) send_item(ideacfb_pkg::CMD_DATA, 8'hC3);

    // Random phases: mostly data bytes, sometimes a restart mid-block.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      quiet_src  = (ph == 4);
      quiet_sink = (ph == 4);
      random_keys();
      write_reg(ideacfb_pkg::REG_DECRYPT_MODE, 64'($urandom_range(1)));
      send_item(ideacfb_pkg::CMD_RESTART, 8'($urandom));
      for (int i = 0; i < NumRandom / 10; i++) begin
        b = 8'($urandom);
        send_item(($urandom_range(99) < 4) ? ideacfb_pkg::CMD_RESTART
                                            : ideacfb_pkg::CMD_DATA, b);
        if (ph == 6 && i == 40) drain();   // sender holds until all bytes are out
      end
    end
    drain();

    $display("covered %0d data bytes and %0d restarts over %0d key settings, both modes",
             data_bytes, restarts, 13);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** idea_cfb_byte_stream_cipher: PASSED **");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", sb.mismatches, sb.pending.size());
      $display("** idea_cfb_byte_stream_cipher: FAILED **");
    end
    $finish;
  end
endmodule
